// ----- sv/irpwfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, timing constants and code table for the IR pulse-width frame decoder.
package irpwfd_pkg;

    localparam int TABLE_ENTRIES_DEF = 48;
    localparam int FRAME_BITS_DEF    = 32;
    localparam int ROM_SIZE          = 48;

    localparam int INTERVAL_W = 20;
    localparam int TOL_W      = 10;
    localparam int PREFIX_W   = 16;
    localparam int SKIP_W     = 4;
    localparam int CODE_W     = 16;
    localparam int INDEX_W    = 6;
    localparam int FRAME_W    = 32;
    localparam int RCNT_W     = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CENTER_W   = 17;
    localparam int SUM_W      = 21;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CENTER_W-1:0] LEADER_PULSE_US = CENTER_W'(9000);
    localparam logic [CENTER_W-1:0] LEADER_SPACE_US = CENTER_W'(4500);
    localparam logic [CENTER_W-1:0] REPEAT_SPACE_US = CENTER_W'(2300);
    localparam logic [CENTER_W-1:0] DATA_PULSE_US   = CENTER_W'(510);
    localparam logic [CENTER_W-1:0] ONE_SPACE_US    = CENTER_W'(1750);
    localparam logic [CENTER_W-1:0] ZERO_SPACE_US   = CENTER_W'(600);
    localparam logic [CENTER_W-1:0] GAP_US          = CENTER_W'(96400);

    localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

    localparam logic [TOL_W-1:0]    TOLERANCE_RST = TOL_W'(100);
    localparam logic [PREFIX_W-1:0] PREFIX_RST    = PREFIX_W'(8415);
    localparam logic [SKIP_W-1:0]   SKIP_RST      = SKIP_W'(2);

    typedef logic [INTERVAL_W-1:0] interval_t;
    typedef logic [TOL_W-1:0]      tolerance_t;
    typedef logic [PREFIX_W-1:0]   prefix_t;
    typedef logic [SKIP_W-1:0]     skip_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [INDEX_W-1:0]    key_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [1:0] {
        CFG_TOLERANCE   = 2'd0,
        CFG_PREFIX      = 2'd1,
        CFG_REPEAT_SKIP = 2'd2
    } cfg_addr_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_PULSE = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_REP_PULSE  = 3'd3,
        PH_REP_SPACE  = 3'd4,
        PH_DATA_PULSE = 3'd5,
        PH_DATA_SPACE = 3'd6
    } phase_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               is_repeat;
    } emit_req_t;

    localparam code_t CODE_ROM [ROM_SIZE] = '{
        16'h10EF, 16'h0FF0, 16'hD02F, 16'hC23D, 16'h9E61, 16'h9C63, 16'h8877, 16'h48B7,
        16'hC837, 16'h28D7, 16'hA857, 16'h6897, 16'hE817, 16'h18E7, 16'h9867, 16'hD52A,
        16'h08F7, 16'h58A7, 16'h40BF, 16'h7887, 16'h00FF, 16'h55AA, 16'hC03F, 16'h906F,
        16'h807F, 16'hF906, 16'h3EC1, 16'h42BD, 16'h04FB, 16'h02FD, 16'h847B, 16'hE01F,
        16'h22DD, 16'h609F, 16'h14EB, 16'h827D, 16'hDA25, 16'h8976, 16'hBD42, 16'h8D72,
        16'hF10E, 16'h0DF2, 16'h718E, 16'h5DA2, 16'h4EB1, 16'h8E71, 16'hC639, 16'h8679
    };

    // center - tol <= w <= center + tol, lower bound clipped at zero
    function automatic logic near(interval_t w, tolerance_t tol, logic [CENTER_W-1:0] center);
        logic [SUM_W-1:0] w_plus;
        logic [SUM_W-1:0] c_plus;
        begin
            w_plus = SUM_W'(w) + SUM_W'(tol);
            c_plus = SUM_W'(center) + SUM_W'(tol);
            return (w_plus >= SUM_W'(center)) && (SUM_W'(w) <= c_plus);
        end
    endfunction

    function automatic logic above(interval_t w, tolerance_t tol, logic [CENTER_W-1:0] center);
        return SUM_W'(w) > (SUM_W'(center) + SUM_W'(tol));
    endfunction

endpackage

// ----- sv/irpwfd_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: interval words in, key words out, configuration writes.
interface irpwfd_in_if import irpwfd_pkg::*; ();
    logic      valid;
    logic      ready;
    interval_t interval_us;
    modport source (output valid, output interval_us, input ready);
    modport sink (input valid, input interval_us, output ready);
endinterface

interface irpwfd_key_if import irpwfd_pkg::*; ();
    logic       valid;
    logic       ready;
    key_index_t key_index;
    code_t      command_code;
    logic       is_repeat;
    modport source (output valid, output key_index, output command_code, output is_repeat,
                    input ready);
    modport sink (input valid, input key_index, input command_code, input is_repeat,
                  output ready);
endinterface

interface irpwfd_cfg_if import irpwfd_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_addr_t addr;
    cfg_data_t data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- sv/irpwfd_front.sv -----
`timescale 1ns / 1ps
// Front end: pulse-width state machine that builds frames and issues emit requests.
module irpwfd_front import irpwfd_pkg::*; #(
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    irpwfd_in_if.sink    in_ch,
    input  tolerance_t   tolerance,
    input  skip_t        repeat_skip,
    input  logic         q_full,
    output logic         push,
    output emit_req_t    push_data
);

    localparam int BC_W = $clog2(FRAME_BITS + 1);

    phase_t                  phase_reg, phase_next;
    logic [BC_W-1:0]         bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0]   shift_reg, shift_next;
    logic [FRAME_BITS-1:0]   last_frame_reg, last_frame_next;
    logic [RCNT_W-1:0]       repeat_count_reg, repeat_count_next;

    logic      accept;
    interval_t w;
    logic      gap, long_rep, frame_done;
    logic      n_lead, n_lspace, n_rspace, n_pulse, n_one, n_zero;
    logic [RCNT_W-1:0] rc_inc;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign w           = in_ch.interval_us;

    assign gap        = above(w, tolerance, GAP_US);
    assign long_rep   = above(w, tolerance, LEADER_PULSE_US);
    assign n_lead     = near(w, tolerance, LEADER_PULSE_US);
    assign n_lspace   = near(w, tolerance, LEADER_SPACE_US);
    assign n_rspace   = near(w, tolerance, REPEAT_SPACE_US);
    assign n_pulse    = near(w, tolerance, DATA_PULSE_US);
    assign n_one      = near(w, tolerance, ONE_SPACE_US);
    assign n_zero     = near(w, tolerance, ZERO_SPACE_US);
    assign frame_done = bit_count_reg >= BC_W'(FRAME_BITS);
    assign rc_inc     = (repeat_count_reg == RCNT_MAX) ? repeat_count_reg
                                                       : repeat_count_reg + RCNT_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (gap)
            begin
                phase_next = PH_LEAD_PULSE;
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD_PULSE: phase_next = n_lead ? PH_LEAD_SPACE : PH_IDLE;
                    PH_LEAD_SPACE:
                    begin
                        if (n_lspace)
                            phase_next = PH_DATA_PULSE;
                        else if (n_rspace)
                            phase_next = PH_REP_PULSE;
                        else
                            phase_next = PH_IDLE;
                    end
                    PH_REP_PULSE:  phase_next = n_pulse ? PH_REP_SPACE : PH_IDLE;
                    PH_REP_SPACE:  phase_next = long_rep ? PH_LEAD_PULSE : PH_IDLE;
                    PH_DATA_PULSE:
                    begin
                        if (!n_pulse)
                            phase_next = PH_IDLE;
                        else if (frame_done)
                            phase_next = PH_REP_SPACE;
                        else
                            phase_next = PH_DATA_SPACE;
                    end
                    PH_DATA_SPACE: phase_next = (n_one || n_zero) ? PH_DATA_PULSE : PH_IDLE;
                    default:       phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        last_frame_next   = last_frame_reg;
        repeat_count_next = repeat_count_reg;
        push              = 1'b0;
        push_data.frame     = FRAME_W'(last_frame_reg);
        push_data.is_repeat = 1'b1;
        if (accept && !gap)
        begin
            case (phase_reg)
                PH_LEAD_SPACE:
                begin
                    if (n_lspace)
                    begin
                        bit_count_next    = '0;
                        shift_next        = '0;
                        repeat_count_next = '0;
                    end
                end
                PH_REP_SPACE:
                begin
                    if (long_rep)
                    begin
                        repeat_count_next = rc_inc;
                        push              = rc_inc > RCNT_W'(repeat_skip);
                    end
                end
                PH_DATA_PULSE:
                begin
                    if (n_pulse && frame_done)
                    begin
                        last_frame_next     = shift_reg;
                        push                = 1'b1;
                        push_data.frame     = FRAME_W'(shift_reg);
                        push_data.is_repeat = 1'b0;
                    end
                end
                PH_DATA_SPACE:
                begin
                    if (n_one || n_zero)
                    begin
                        shift_next     = {shift_reg[FRAME_BITS-2:0], n_one};
                        bit_count_next = bit_count_reg + BC_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_reg        <= '0;
            last_frame_reg   <= '0;
            repeat_count_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            last_frame_reg   <= last_frame_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

    a_gap_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && gap |=> phase_reg == PH_LEAD_PULSE)
        else $error("long interval did not rearm decoder");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept && !q_full)
        else $error("emit request without accepted word");

    a_fresh_frame_full: assert property (@(posedge clk) disable iff (!rst_n)
        push && !push_data.is_repeat |->
            phase_reg == PH_DATA_PULSE && bit_count_reg == BC_W'(FRAME_BITS))
        else $error("fresh frame emitted before all bits received");

endmodule

// ----- sv/irpwfd_queue.sv -----
`timescale 1ns / 1ps
// Small FIFO of emit requests between the front end and the lookup stage.
module irpwfd_queue import irpwfd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  emit_req_t  push_data,
    output logic       full,
    input  logic       pop,
    output emit_req_t  head,
    output logic       nonempty
);

    emit_req_t            mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign full     = count_reg == Q_CNT_W'(Q_DEPTH);
    assign nonempty = count_reg != '0;
    assign head     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- sv/irpwfd_back.sv -----
`timescale 1ns / 1ps
// Back end: prefix check, code table search and output register.
module irpwfd_back import irpwfd_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  prefix_t       address_prefix,
    input  logic          q_valid,
    input  emit_req_t     head,
    output logic          pop,
    irpwfd_key_if.source  key
);

    localparam int LIMIT = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;

    logic        valid_reg, valid_next;
    key_index_t  index_reg;
    code_t       code_reg;
    logic        rep_reg;

    code_t       code;
    logic        rom_hit, hit;
    key_index_t  idx;

    assign code = head.frame[CODE_W-1:0];
    assign pop  = q_valid && (!valid_reg || key.ready);

    // lowest matching entry wins
    always_comb
    begin
        rom_hit = 1'b0;
        idx     = '0;
        for (int i = LIMIT - 1; i >= 0; i--)
        begin
            if (CODE_ROM[i] == code)
            begin
                rom_hit = 1'b1;
                idx     = INDEX_W'(i);
            end
        end
        hit = rom_hit && (head.frame[FRAME_W-1:CODE_W] == address_prefix);
    end

    always_comb
    begin
        if (pop && hit)
            valid_next = 1'b1;
        else if (key.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && hit)
        begin
            index_reg <= idx;
            code_reg  <= code;
            rep_reg   <= head.is_repeat;
        end
    end

    assign key.valid        = valid_reg;
    assign key.key_index    = index_reg;
    assign key.command_code = code_reg;
    assign key.is_repeat    = rep_reg;

    a_hit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop && hit |=> key.valid)
        else $error("matched frame not presented");

    a_miss_drops: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !hit && key.ready |=> !key.valid)
        else $error("unmatched frame produced a word");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        key.valid |-> key.key_index < INDEX_W'(LIMIT))
        else $error("key index beyond table");

endmodule

// ----- sv/ir_pulse_width_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the IR pulse-width frame decoder.
//
// Usage: the interval channel carries one word per receiver edge, the time in
// microseconds since the previous edge. The key channel returns one word per
// decoded frame (or per re-emitted repeat) whose upper 16 bits match the
// address prefix and whose command is found in the code table: table index,
// command and a repeat flag. Unmatched frames and plain pulses give no word.
// The cfg channel writes tolerance, address prefix and repeat skip; it is
// always ready and should be used only while the decoder is idle.
// Throughput: one interval word per cycle while the queue is not full. A key
// word passes the state machine step, a 2-entry queue and the table search
// into the output register, which presents it on the key channel.
// When the key receiver stalls, the output register holds its word, the queue
// fills, and interval ready drops only once the queue is full.
// Reset: decoder idle waiting for a long gap, stored frame and counters zero,
// registers at tolerance 100, prefix 8415, repeat skip 2; no clearing pass.
module ir_pulse_width_frame_decoder_unit import irpwfd_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int FRAME_BITS    = FRAME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    irpwfd_in_if.sink     interval,
    irpwfd_key_if.source  key,
    irpwfd_cfg_if.sink    cfg
);

    tolerance_t tolerance_reg;
    prefix_t    prefix_reg;
    skip_t      skip_reg;

    logic       q_full;
    logic       push;
    emit_req_t  push_data;
    logic       pop;
    emit_req_t  head;
    logic       q_valid;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RST;
            prefix_reg    <= PREFIX_RST;
            skip_reg      <= SKIP_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                CFG_TOLERANCE:   tolerance_reg <= cfg.data[TOL_W-1:0];
                CFG_PREFIX:      prefix_reg    <= cfg.data[PREFIX_W-1:0];
                CFG_REPEAT_SKIP: skip_reg      <= cfg.data[SKIP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    irpwfd_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (interval),
        .tolerance   (tolerance_reg),
        .repeat_skip (skip_reg),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    irpwfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .nonempty  (q_valid)
    );

    irpwfd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .address_prefix (prefix_reg),
        .q_valid        (q_valid),
        .head           (head),
        .pop            (pop),
        .key            (key)
    );

endmodule

// ----- dv/tb_ir_pulse_width_frame_decoder_unit.sv -----
`timescale 1ns / 1ps
// Testbench for the IR frame decoder: directed rows and random traffic checked against a model.
module tb_ir_pulse_width_frame_decoder_unit;
    import irpwfd_pkg::*;

    localparam int unsigned T_LEAD_PULSE = 9000;
    localparam int unsigned T_LEAD_SPACE = 4500;
    localparam int unsigned T_REP_SPACE  = 2300;
    localparam int unsigned T_BIT_PULSE  = 510;
    localparam int unsigned T_ONE_SPACE  = 1750;
    localparam int unsigned T_ZERO_SPACE = 600;
    localparam int unsigned T_GAP        = 96400;
    localparam int unsigned MAX_INTERVAL = 1048575;
    localparam int          FRAME_LEN    = 32;
    localparam int          KEY_ROM_LEN  = 48;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 8;

    typedef struct packed {
        key_index_t idx;
        code_t      code;
        logic       rep;
    } key_word_t;

    typedef enum int {ROW_RAW, ROW_FRAME, ROW_REPEAT} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [31:0] value;
        int          skew;
        bit          typed;
        key_word_t   want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    irpwfd_in_if  in_ch ();
    irpwfd_key_if key_ch ();
    irpwfd_cfg_if cfg_ch ();

    ir_pulse_width_frame_decoder_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .interval (in_ch),
        .key      (key_ch),
        .cfg      (cfg_ch)
    );

    logic [15:0] key_rom [0:KEY_ROM_LEN-1] = '{
        16'h10EF, 16'h0FF0, 16'hD02F, 16'hC23D, 16'h9E61, 16'h9C63, 16'h8877, 16'h48B7,
        16'hC837, 16'h28D7, 16'hA857, 16'h6897, 16'hE817, 16'h18E7, 16'h9867, 16'hD52A,
        16'h08F7, 16'h58A7, 16'h40BF, 16'h7887, 16'h00FF, 16'h55AA, 16'hC03F, 16'h906F,
        16'h807F, 16'hF906, 16'h3EC1, 16'h42BD, 16'h04FB, 16'h02FD, 16'h847B, 16'hE01F,
        16'h22DD, 16'h609F, 16'h14EB, 16'h827D, 16'hDA25, 16'h8976, 16'hBD42, 16'h8D72,
        16'hF10E, 16'h0DF2, 16'h718E, 16'h5DA2, 16'h4EB1, 16'h8E71, 16'hC639, 16'h8679
    };

    // decoder model state and registers
    tolerance_t  dec_tol;
    prefix_t     dec_prefix;
    skip_t       dec_skip;
    phase_t      dec_phase;
    logic [5:0]  dec_bits;
    logic [31:0] dec_shift;
    logic [31:0] dec_last;
    logic [4:0]  dec_repeats;

    key_word_t pending_keys[$];
    key_word_t got_want;
    dir_row_t  dir_rows[$];
    int        burst_q[$];

    int errors;
    int items_sent;
    int expect_total;
    int words_checked;
    int repeats_checked;
    int settings_used;
    int src_mode;
    int sink_mode;
    bit hold_req;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit in_window(input int unsigned w, input int unsigned center);
        return (w + dec_tol >= center) && (w <= center + dec_tol);
    endfunction

    task automatic lookup_key(input logic [31:0] frame, input logic rep);
        bit found;
        key_word_t kw;
        begin
            found = 1'b0;
            if (frame[31:16] == dec_prefix)
            begin
                for (int i = 0; i < KEY_ROM_LEN; i++)
                begin
                    if (!found && key_rom[i] == frame[15:0])
                    begin
                        found = 1'b1;
                        kw.idx = key_index_t'(i);
                        kw.code = frame[15:0];
                        kw.rep = rep;
                        pending_keys.push_back(kw);
                        expect_total++;
                    end
                end
            end
        end
    endtask

    task automatic predict_interval(input interval_t w);
        int unsigned wi;
        begin
            wi = w;
            if (wi > T_GAP + dec_tol)
                dec_phase = PH_LEAD_PULSE;
            else
            begin
                case (dec_phase)
                    PH_LEAD_PULSE:
                        dec_phase = in_window(wi, T_LEAD_PULSE) ? PH_LEAD_SPACE : PH_IDLE;
                    PH_LEAD_SPACE:
                        if (in_window(wi, T_LEAD_SPACE))
                        begin
                            dec_bits = '0;
                            dec_shift = '0;
                            dec_repeats = '0;
                            dec_phase = PH_DATA_PULSE;
                        end
                        else if (in_window(wi, T_REP_SPACE))
                            dec_phase = PH_REP_PULSE;
                        else
                            dec_phase = PH_IDLE;
                    PH_REP_PULSE:
                        dec_phase = in_window(wi, T_BIT_PULSE) ? PH_REP_SPACE : PH_IDLE;
                    PH_REP_SPACE:
                        if (wi > T_LEAD_PULSE + dec_tol)
                        begin
                            dec_phase = PH_LEAD_PULSE;
                            if (dec_repeats != 5'd31)
                                dec_repeats = dec_repeats + 5'd1;
                            if (dec_repeats > dec_skip)
                                lookup_key(dec_last, 1'b1);
                        end
                        else
                            dec_phase = PH_IDLE;
                    PH_DATA_PULSE:
                        if (in_window(wi, T_BIT_PULSE))
                        begin
                            if (dec_bits >= FRAME_LEN)
                            begin
                                dec_phase = PH_REP_SPACE;
                                dec_last = dec_shift;
                                lookup_key(dec_last, 1'b0);
                            end
                            else
                                dec_phase = PH_DATA_SPACE;
                        end
                        else
                            dec_phase = PH_IDLE;
                    PH_DATA_SPACE:
                        if (in_window(wi, T_ONE_SPACE))
                        begin
                            dec_shift = {dec_shift[30:0], 1'b1};
                            dec_bits = dec_bits + 6'd1;
                            dec_phase = PH_DATA_PULSE;
                        end
                        else if (in_window(wi, T_ZERO_SPACE))
                        begin
                            dec_shift = {dec_shift[30:0], 1'b0};
                            dec_bits = dec_bits + 6'd1;
                            dec_phase = PH_DATA_PULSE;
                        end
                        else
                            dec_phase = PH_IDLE;
                    default:
                        ;
                endcase
            end
        end
    endtask

    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (r < ((mode == 1) ? 80 : 50))
            return 0;
        if (r < ((mode == 1) ? 97 : 85))
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_skew();
        int t;
        int r;
        t = dec_tol;
        r = $urandom_range(0, 9);
        if (r == 0)
            return t;
        if (r == 1)
            return -t;
        return int'($urandom_range(0, 2 * t)) - t;
    endfunction

    task automatic send_interval(input int unsigned raw);
        interval_t w;
        int gap;
        begin
            w = (raw > MAX_INTERVAL) ? interval_t'(MAX_INTERVAL) : interval_t'(raw);
            gap = pick_gap(src_mode);
            @(negedge clk);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.interval_us <= w;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            predict_interval(w);
            items_sent++;
        end
    endtask

    task automatic send_nominal(input int center, input int skew);
        int v;
        begin
            v = center + skew;
            if (v < 0)
                v = 0;
            send_interval(v);
        end
    endtask

    task automatic load_frame(input logic [31:0] f);
        begin
            burst_q.delete();
            burst_q.push_back(T_LEAD_PULSE);
            burst_q.push_back(T_LEAD_SPACE);
            for (int b = FRAME_LEN - 1; b >= 0; b--)
            begin
                burst_q.push_back(T_BIT_PULSE);
                burst_q.push_back(f[b] ? T_ONE_SPACE : T_ZERO_SPACE);
            end
            burst_q.push_back(T_BIT_PULSE);
        end
    endtask

    task automatic load_repeat();
        begin
            burst_q.delete();
            burst_q.push_back(T_LEAD_PULSE);
            burst_q.push_back(T_REP_SPACE);
            burst_q.push_back(T_BIT_PULSE);
        end
    endtask

    task automatic play_burst(input int skew, input bit jitter, input int corrupt_at);
        begin
            for (int i = 0; i < burst_q.size(); i++)
            begin
                if (i == corrupt_at)
                    send_interval($urandom_range(0, 20000));
                else
                    send_nominal(burst_q[i], jitter ? pick_skew() : skew);
            end
        end
    endtask

    task automatic pause_source();
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_keys.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_addr_t a, input cfg_data_t d);
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr <= a;
            cfg_ch.data <= d;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            case (a)
                CFG_TOLERANCE:   dec_tol = d[TOL_W-1:0];
                CFG_PREFIX:      dec_prefix = d[PREFIX_W-1:0];
                CFG_REPEAT_SKIP: dec_skip = d[SKIP_W-1:0];
                default:         ;
            endcase
            @(negedge clk);
            cfg_ch.valid <= 1'b0;
        end
    endtask

    task automatic set_decoder_regs(input int tol, input int prefix, input int skip);
        int junk;
        begin
            pause_source();
            wait_drained();
            junk = $urandom_range(0, 63);
            write_reg(CFG_TOLERANCE, cfg_data_t'((junk << TOL_W) | tol));
            write_reg(CFG_PREFIX, cfg_data_t'(prefix));
            write_reg(CFG_REPEAT_SKIP, cfg_data_t'(skip));
            settings_used++;
        end
    endtask

    task automatic add_row(input row_kind_t kind, input logic [31:0] value, input int skew,
                           input bit typed, input int idx, input int code, input bit rep);
        dir_row_t row;
        begin
            row.kind = kind;
            row.value = value;
            row.skew = skew;
            row.typed = typed;
            row.want.idx = key_index_t'(idx);
            row.want.code = code_t'(code);
            row.want.rep = rep;
            dir_rows.push_back(row);
        end
    endtask

    function automatic logic [31:0] make_frame();
        logic [15:0] upper;
        logic [15:0] lower;
        upper = ($urandom_range(0, 99) < 85) ? dec_prefix : 16'($urandom);
        lower = ($urandom_range(0, 99) < 80) ? key_rom[$urandom_range(0, KEY_ROM_LEN - 1)]
                                             : 16'($urandom);
        return {upper, lower};
    endfunction

    function automatic int unsigned long_gap();
        return $urandom_range(T_GAP + dec_tol + 1, MAX_INTERVAL);
    endfunction

    function automatic int unsigned repeat_gap();
        return $urandom_range(T_LEAD_PULSE + dec_tol + 1, T_GAP + dec_tol);
    endfunction

    task automatic send_repeats(input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                send_interval(repeat_gap());
                load_repeat();
                play_burst(0, 1'b1, -1);
            end
            send_interval(($urandom_range(0, 1) == 0) ? repeat_gap() : long_gap());
        end
    endtask

    task automatic run_random_sequence();
        int r;
        int n;
        begin
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                            : $urandom_range(0, dec_skip + 3);
            if (r < 55)
            begin
                send_interval(long_gap());
                load_frame(make_frame());
                play_burst(0, 1'b1, -1);
                send_repeats(n);
            end
            else if (r < 70)
            begin
                send_interval(long_gap());
                send_repeats(n);
            end
            else if (r < 85)
            begin
                send_interval(long_gap());
                if ($urandom_range(0, 3) == 0)
                    load_repeat();
                else
                    load_frame(make_frame());
                play_burst(0, 1'b1, $urandom_range(0, burst_q.size() - 1));
            end
            else
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0:       send_interval($urandom_range(0, MAX_INTERVAL));
                        1:       send_nominal(T_ONE_SPACE, pick_skew());
                        default: send_interval($urandom_range(0, 20000));
                    endcase
                end
            end
        end
    endtask

    // key word checker
    always @(posedge clk)
    begin
        if (rst_n && key_ch.valid && key_ch.ready)
        begin
            if (pending_keys.size() == 0)
            begin
                $error("unexpected key word: index %0d code %h repeat %0d",
                       key_ch.key_index, key_ch.command_code, key_ch.is_repeat);
                errors++;
            end
            else
            begin
                got_want = pending_keys.pop_front();
                words_checked++;
                if (key_ch.is_repeat)
                    repeats_checked++;
                if (key_ch.key_index !== got_want.idx)
                begin
                    $error("key_index: expected %0d, got %0d", got_want.idx, key_ch.key_index);
                    errors++;
                end
                if (key_ch.command_code !== got_want.code)
                begin
                    $error("command_code: expected %h, got %h", got_want.code,
                           key_ch.command_code);
                    errors++;
                end
                if (key_ch.is_repeat !== got_want.rep)
                begin
                    $error("is_repeat: expected %0d, got %0d", got_want.rep, key_ch.is_repeat);
                    errors++;
                end
            end
        end
    end

    // key receiver: random stalls plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        key_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                key_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                key_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                key_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap(sink_mode);
                key_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        int before_cnt;
        int start_items;
        dir_row_t row;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.interval_us = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = CFG_TOLERANCE;
        cfg_ch.data = '0;
        hold_req = 1'b0;
        errors = 0;
        items_sent = 0;
        expect_total = 0;
        words_checked = 0;
        repeats_checked = 0;
        settings_used = 1;
        src_mode = 1;
        sink_mode = 1;

        dec_tol = 10'd100;
        dec_prefix = 16'd8415;
        dec_skip = 4'd2;
        dec_phase = PH_IDLE;
        dec_bits = '0;
        dec_shift = '0;
        dec_last = '0;
        dec_repeats = '0;

        // directed rows, reset settings: tolerance 100, prefix 20DF, skip 2
        add_row(ROW_RAW,    0,            0,    0, 0,  0,       0);
        add_row(ROW_RAW,    MAX_INTERVAL, 0,    0, 0,  0,       0);
        add_row(ROW_REPEAT, 0,            0,    0, 0,  0,       0);
        add_row(ROW_RAW,    50000,        0,    0, 0,  0,       0);
        add_row(ROW_REPEAT, 0,            0,    0, 0,  0,       0);
        add_row(ROW_RAW,    50000,        0,    0, 0,  0,       0);
        add_row(ROW_REPEAT, 0,            0,    0, 0,  0,       0);
        add_row(ROW_RAW,    96500,        0,    0, 0,  0,       0);
        add_row(ROW_RAW,    96501,        0,    0, 0,  0,       0);
        add_row(ROW_FRAME,  32'h20DF10EF, 0,    1, 0,  'h10EF,  0);
        add_row(ROW_RAW,    9101,         0,    0, 0,  0,       0);
        add_row(ROW_REPEAT, 0,            100,  0, 0,  0,       0);
        add_row(ROW_RAW,    9101,         0,    0, 0,  0,       0);
        add_row(ROW_REPEAT, 0,            -100, 0, 0,  0,       0);
        add_row(ROW_RAW,    20000,        0,    1, 0,  'h10EF,  1);
        add_row(ROW_FRAME,  32'h20DF8679, 100,  1, 47, 'h8679,  0);
        add_row(ROW_RAW,    9100,         0,    0, 0,  0,       0);
        add_row(ROW_RAW,    200000,       0,    0, 0,  0,       0);
        add_row(ROW_FRAME,  32'h20DF22DD, -100, 1, 32, 'h22DD,  0);
        add_row(ROW_RAW,    96600,        0,    0, 0,  0,       0);
        add_row(ROW_FRAME,  32'h123410EF, 0,    0, 0,  0,       0);
        add_row(ROW_RAW,    96600,        0,    0, 0,  0,       0);
        add_row(ROW_FRAME,  32'h20DF1234, 0,    0, 0,  0,       0);
        add_row(ROW_RAW,    96600,        0,    0, 0,  0,       0);
        add_row(ROW_FRAME,  32'h20DF0FF0, 101,  0, 0,  0,       0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < dir_rows.size(); k++)
        begin
            row = dir_rows[k];
            before_cnt = expect_total;
            case (row.kind)
                ROW_RAW:
                    send_interval(row.value);
                ROW_FRAME:
                begin
                    load_frame(row.value);
                    play_burst(row.skew, 1'b0, -1);
                end
                default:
                begin
                    load_repeat();
                    play_burst(row.skew, 1'b0, -1);
                end
            endcase
            if (row.typed)
            begin
                if (expect_total != before_cnt + 1)
                begin
                    $error("directed row %0d: model gave %0d key words", k,
                           expect_total - before_cnt);
                    errors++;
                end
                else
                begin
                    if (pending_keys[pending_keys.size() - 1] != row.want)
                    begin
                        $error("directed row %0d: model disagrees with table", k);
                        errors++;
                    end
                    pending_keys[pending_keys.size() - 1] = row.want;
                end
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       set_decoder_regs(0, 0, 0);
                1:       set_decoder_regs(1023, 'hFFFF, 15);
                2:       set_decoder_regs($urandom_range(0, 1023), $urandom_range(0, 'hFFFF),
                                          $urandom_range(0, 15));
                3:       set_decoder_regs(600, $urandom_range(0, 'hFFFF), 1);
                4:       set_decoder_regs($urandom_range(0, 1023), $urandom_range(0, 'hFFFF),
                                          $urandom_range(0, 15));
                default: set_decoder_regs(100, 8415, 2);
            endcase
            src_mode = p % 3;
            sink_mode = (p + 1) % 3;
            start_items = items_sent;

            if (p == 0)
            begin
                // every repeat emits: receiver holds off, queue fills, input stalls
                hold_req = 1'b1;
                send_interval(long_gap());
                load_frame({16'h0000, key_rom[5]});
                play_burst(0, 1'b1, -1);
                send_repeats(30);
            end

            if (p == 1)
            begin
                run_random_sequence();
                pause_source();
                while (pending_keys.size() != 0)
                    @(posedge clk);
            end

            while (items_sent - start_items < 40)
                run_random_sequence();
        end

        pause_source();
        wait_drained();

        $display("run covered %0d directed rows and %0d intervals over %0d register settings",
                 dir_rows.size(), items_sent, settings_used);
        $display("%0d key words checked, %0d of them from repeat frames",
                 words_checked, repeats_checked);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
